// File: hdl/bidirectional_address_map_assert.svh
// assertion macros for the bidirectional address map
// used by the top level only; needs a clock and an active-low reset in scope
`ifndef BIDIRECTIONAL_ADDRESS_MAP_ASSERT_SVH
`define BIDIRECTIONAL_ADDRESS_MAP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BAM_ASSERT_NOW(lbl, clk_sig, rst_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
		else $error("bam assertion failed");

// next-cycle implication, checked outside reset
`define BAM_ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
		else $error("bam assertion failed");

`endif

// File: hdl/bam_pkg.sv
// shared types and constants of the bidirectional address map
// no dependencies
package bam_pkg;

	localparam int ENTRIES  = 16;
	localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OP_W     = 3;
	localparam int STATUS_W = 2;
	localparam int SHORT_W  = 16;
	localparam int LONG_W   = 64;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
	localparam logic [OP_W-1:0] OP_FIND_SHORT = 3'd1;
	localparam logic [OP_W-1:0] OP_FIND_LONG  = 3'd2;
	localparam logic [OP_W-1:0] OP_DEL_LONG   = 3'd3;
	localparam logic [OP_W-1:0] OP_DEL_SHORT  = 3'd4;

	// result codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_COMMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
	} sts_t;

endpackage

// File: hdl/bam_if.sv
// request and response channel interfaces of the bidirectional address map
// depends on bam_pkg
interface bam_req_if;
	logic                         valid;
	logic                         ready;
	logic [bam_pkg::OP_W-1:0]     opcode;
	logic [bam_pkg::SHORT_W-1:0]  short_key;
	logic [bam_pkg::LONG_W-1:0]   long_key;

	modport source (output valid, opcode, short_key, long_key, input ready);
	modport sink (input valid, opcode, short_key, long_key, output ready);
endinterface

interface bam_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [bam_pkg::STATUS_W-1:0] status;
	logic [bam_pkg::SHORT_W-1:0]  short_out;
	logic [bam_pkg::LONG_W-1:0]   long_out;

	modport source (output valid, status, short_out, long_out, input ready);
	modport sink (input valid, status, short_out, long_out, output ready);
endinterface

// File: hdl/bidirectional_address_map.sv
// bidirectional address map: short/long address table searchable by either key
// usage: req carries opcode, short_key and long_key; rsp returns status,
//   short_out and long_out, one rsp item for every req item, in order
// an item is taken when req.valid and req.ready are high at a clock edge
// after acceptance the controller sweeps the ENTRIES slots through the
//   short and long address rams, one slot a cycle, then spends a drain step
//   on the last compare and a commit step on the table update and result load
// a new item is not taken until the previous one has left the update step,
//   as the single read port of each ram is busy during the sweep
// the result sits in an output register, so req.ready returns while a
//   result still waits; when rsp.ready stays low the next item is scanned
//   and then held in the update step until the output register frees
// reset (arst_n low) empties the table at once by clearing the valid bits;
//   ram contents of an invalid slot are never used, so no clearing pass
// depends on bam_pkg, bam_if, bam_ram, bam_datapath, bam_ctrl and
//   bidirectional_address_map_assert.svh
`include "bidirectional_address_map_assert.svh"

module bidirectional_address_map (
	input  logic  clk,
	input  logic  arst_n,
	bam_req_if.sink   req,
	bam_rsp_if.source rsp
);

	// command and status between the controller and the datapath
	bam_pkg::cmd_t cmd;
	bam_pkg::sts_t sts;

	// sequencing
	bam_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// table, scan compare and result register
	bam_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.opcode    (req.opcode),
		.short_key (req.short_key),
		.long_key  (req.long_key),
		.status    (rsp.status),
		.short_out (rsp.short_out),
		.long_out  (rsp.long_out)
	);

	// no new item is taken while one is being scanned
	`BAM_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready)
	// a result only appears from an update step
	`BAM_ASSERT_NOW(a_result_from_commit, clk, arst_n, $rose(rsp.valid), $past(cmd.commit))
	// the sweep ends after the last slot is read
	`BAM_ASSERT_NEXT(a_scan_ends, clk, arst_n, cmd.scan && sts.scan_last, !cmd.scan)

endmodule

// File: hdl/bam_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module bam_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/bam_datapath.sv
// table storage, scan compare and update logic of the address map
// depends on bam_pkg and bam_ram
module bam_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bam_pkg::cmd_t                 cmd,
	output bam_pkg::sts_t                 sts,
	input  logic [bam_pkg::OP_W-1:0]      opcode,
	input  logic [bam_pkg::SHORT_W-1:0]   short_key,
	input  logic [bam_pkg::LONG_W-1:0]    long_key,
	output logic [bam_pkg::STATUS_W-1:0]  status,
	output logic [bam_pkg::SHORT_W-1:0]   short_out,
	output logic [bam_pkg::LONG_W-1:0]    long_out
);

	localparam int IW = bam_pkg::IDX_W;

	// captured item
	logic [bam_pkg::OP_W-1:0]    op_q;
	logic [bam_pkg::SHORT_W-1:0] skey_q;
	logic [bam_pkg::LONG_W-1:0]  lkey_q;

	// scan address and compare stage
	logic [IW-1:0] rd_addr_q;
	logic          cmp_vld_s1;
	logic [IW-1:0] cmp_idx_s1;

	logic [bam_pkg::ENTRIES-1:0] valid_q;

	logic [bam_pkg::SHORT_W-1:0] sh_rdata;
	logic [bam_pkg::LONG_W-1:0]  lg_rdata;

	// first matches and first free slot
	logic                        lm_hit_q, sm_hit_q, fr_hit_q;
	logic [IW-1:0]               lm_idx_q, sm_idx_q, fr_idx_q;
	logic [bam_pkg::SHORT_W-1:0] lm_short_q;
	logic [bam_pkg::LONG_W-1:0]  sm_long_q;

	logic                        cur_valid, hit_l, hit_s, hit_f;

	// update and result
	logic                        sh_we, lg_we, vset, vclr;
	logic [IW-1:0]               sh_waddr, lg_waddr, vset_idx, vclr_idx;
	logic [bam_pkg::STATUS_W-1:0] res_st;
	logic [bam_pkg::SHORT_W-1:0] res_s;
	logic [bam_pkg::LONG_W-1:0]  res_l;

	bam_ram #(.WIDTH(bam_pkg::SHORT_W), .DEPTH(bam_pkg::ENTRIES)) u_short_ram (
		.clk   (clk),
		.we    (sh_we),
		.waddr (sh_waddr),
		.wdata (skey_q),
		.raddr (rd_addr_q),
		.rdata (sh_rdata)
	);

	bam_ram #(.WIDTH(bam_pkg::LONG_W), .DEPTH(bam_pkg::ENTRIES)) u_long_ram (
		.clk   (clk),
		.we    (lg_we),
		.waddr (lg_waddr),
		.wdata (lkey_q),
		.raddr (rd_addr_q),
		.rdata (lg_rdata)
	);

	assign sts.scan_last = (rd_addr_q == IW'(bam_pkg::ENTRIES - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			skey_q <= short_key;
			lkey_q <= long_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q  <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
		end else begin
			if (cmd.load) begin
				rd_addr_q <= '0;
			end else if (cmd.scan) begin
				rd_addr_q <= rd_addr_q + IW'(1);
			end
			cmp_vld_s1 <= cmd.scan;
			cmp_idx_s1 <= rd_addr_q;
		end
	end

	assign cur_valid = valid_q[cmp_idx_s1];
	assign hit_l     = cmp_vld_s1 && cur_valid && (lg_rdata == lkey_q);
	assign hit_s     = cmp_vld_s1 && cur_valid && (sh_rdata == skey_q);
	assign hit_f     = cmp_vld_s1 && !cur_valid;

	// keep the lowest matching slot of each kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lm_hit_q <= 1'b0;
			sm_hit_q <= 1'b0;
			fr_hit_q <= 1'b0;
		end else if (cmd.load) begin
			lm_hit_q <= 1'b0;
			sm_hit_q <= 1'b0;
			fr_hit_q <= 1'b0;
		end else begin
			if (hit_l && !lm_hit_q) begin
				lm_hit_q <= 1'b1;
			end
			if (hit_s && !sm_hit_q) begin
				sm_hit_q <= 1'b1;
			end
			if (hit_f && !fr_hit_q) begin
				fr_hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit_l && !lm_hit_q) begin
			lm_idx_q   <= cmp_idx_s1;
			lm_short_q <= sh_rdata;
		end
		if (hit_s && !sm_hit_q) begin
			sm_idx_q  <= cmp_idx_s1;
			sm_long_q <= lg_rdata;
		end
		if (hit_f && !fr_hit_q) begin
			fr_idx_q <= cmp_idx_s1;
		end
	end

	always_comb begin
		sh_we    = 1'b0;
		lg_we    = 1'b0;
		vset     = 1'b0;
		vclr     = 1'b0;
		sh_waddr = lm_idx_q;
		lg_waddr = sm_idx_q;
		vset_idx = fr_idx_q;
		vclr_idx = lm_idx_q;
		res_st   = bam_pkg::ST_MISS;
		res_s    = '0;
		res_l    = '0;
		case (op_q) inside
			bam_pkg::OP_INSERT: begin
				res_st = bam_pkg::ST_OK;
				res_s  = skey_q;
				res_l  = lkey_q;
				if (lm_hit_q) begin
					sh_we = cmd.commit;
					if (sm_hit_q && (sm_idx_q != lm_idx_q)) begin
						vclr     = cmd.commit;
						vclr_idx = sm_idx_q;
					end
				end else if (sm_hit_q) begin
					lg_we = cmd.commit;
				end else if (fr_hit_q) begin
					sh_we    = cmd.commit;
					lg_we    = cmd.commit;
					vset     = cmd.commit;
					sh_waddr = fr_idx_q;
					lg_waddr = fr_idx_q;
				end else begin
					res_st = bam_pkg::ST_FULL;
					res_s  = '0;
					res_l  = '0;
				end
			end
			bam_pkg::OP_FIND_SHORT, bam_pkg::OP_DEL_LONG: begin
				if (lm_hit_q) begin
					res_st = bam_pkg::ST_OK;
					res_s  = lm_short_q;
					res_l  = lkey_q;
					vclr   = cmd.commit && (op_q == bam_pkg::OP_DEL_LONG);
				end
			end
			bam_pkg::OP_FIND_LONG, bam_pkg::OP_DEL_SHORT: begin
				if (sm_hit_q) begin
					res_st   = bam_pkg::ST_OK;
					res_s    = skey_q;
					res_l    = sm_long_q;
					vclr     = cmd.commit && (op_q == bam_pkg::OP_DEL_SHORT);
					vclr_idx = sm_idx_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (vclr) begin
				valid_q[vclr_idx] <= 1'b0;
			end
			if (vset) begin
				valid_q[vset_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status    <= res_st;
			short_out <= res_s;
			long_out  <= res_l;
		end
	end

endmodule

// File: hdl/bam_ctrl.sv
// sequencing state machine and output valid of the address map
// depends on bam_pkg
module bam_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output bam_pkg::cmd_t cmd,
	input  bam_pkg::sts_t sts
);

	bam_pkg::state_t state_q, state_nx;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			bam_pkg::S_IDLE: begin
				if (in_valid) begin
					state_nx = bam_pkg::S_SCAN;
				end
			end
			bam_pkg::S_SCAN: begin
				if (sts.scan_last) begin
					state_nx = bam_pkg::S_DRAIN;
				end
			end
			bam_pkg::S_DRAIN: begin
				state_nx = bam_pkg::S_COMMIT;
			end
			bam_pkg::S_COMMIT: begin
				if (out_free) begin
					state_nx = bam_pkg::S_IDLE;
				end
			end
			default: begin
				state_nx = bam_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			bam_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			bam_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
			end
			bam_pkg::S_DRAIN: begin
			end
			bam_pkg::S_COMMIT: begin
				cmd.commit = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bam_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
